[design/rfas_pkg.sv]
// ----------------------------------------------------------------------------
// rfas_pkg: shared definitions for the register-file ALU step core
// Data width, register-file geometry, instruction field positions, ALU
// operation codes and the register-file reset contents.
// ----------------------------------------------------------------------------
package rfas_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int REG_COUNT  = 8;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int INSTR_W    = 16;
  localparam int SHAMT_W    = $clog2(DATA_WIDTH);

  // Instruction field positions
  localparam int RA_LSB = 13;
  localparam int RB_LSB = 10;
  localparam int OP_LSB = 2;
  localparam int OP_W   = 3;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [REG_AW-1:0]     reg_addr_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_AND = 3'd2,
    OP_OR  = 3'd3,
    OP_XOR = 3'd4,
    OP_SHL = 3'd5,
    OP_SHR = 3'd6,
    OP_CMP = 3'd7
  } op_t;

  // Compare outcome codes
  localparam data_t CMP_EQ = DATA_WIDTH'(0);
  localparam data_t CMP_GT = DATA_WIDTH'(1);
  localparam data_t CMP_LT = DATA_WIDTH'(2);

  localparam data_t SHIFT_LIMIT = DATA_WIDTH'(DATA_WIDTH);

  localparam data_t RST_VALS [REG_COUNT] = '{
    DATA_WIDTH'(15), DATA_WIDTH'(7),  DATA_WIDTH'(12), DATA_WIDTH'(1),
    DATA_WIDTH'(9),  DATA_WIDTH'(2),  DATA_WIDTH'(22), DATA_WIDTH'(7)
  };

  // Register-file write port
  typedef struct packed {
    logic      en;
    reg_addr_t addr;
    data_t     data;
  } rf_wr_t;

endpackage

[design/rfas_regfile.sv]
// ----------------------------------------------------------------------------
// rfas_regfile: eight-entry register file
// One write port and two read ports with registered read data. Entries that
// have never been written read back as their reset contents.
// ----------------------------------------------------------------------------
module rfas_regfile (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  rfas_pkg::reg_addr_t rd_addr_a,
  input  rfas_pkg::reg_addr_t rd_addr_b,
  input  rfas_pkg::rf_wr_t  wr,
  output rfas_pkg::data_t   rd_data_a,
  output rfas_pkg::data_t   rd_data_b
);

  rfas_pkg::data_t     mem [rfas_pkg::REG_COUNT];
  logic [rfas_pkg::REG_COUNT-1:0] valid_r;
  rfas_pkg::data_t     mem_a_r, mem_b_r;
  logic                vld_a_r, vld_b_r;
  rfas_pkg::reg_addr_t addr_a_r, addr_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // Reads see the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_a_r  <= mem[rd_addr_a];
      mem_b_r  <= mem[rd_addr_b];
      vld_a_r  <= valid_r[rd_addr_a];
      vld_b_r  <= valid_r[rd_addr_b];
      addr_a_r <= rd_addr_a;
      addr_b_r <= rd_addr_b;
    end
  end

  assign rd_data_a = vld_a_r ? mem_a_r : rfas_pkg::RST_VALS[addr_a_r];
  assign rd_data_b = vld_b_r ? mem_b_r : rfas_pkg::RST_VALS[addr_b_r];

endmodule

[design/rfas_alu.sv]
// ----------------------------------------------------------------------------
// rfas_alu: two-operand ALU
// Wrapping add and subtract, bitwise logic, shifts and an unsigned compare.
// ----------------------------------------------------------------------------
module rfas_alu (
  input  rfas_pkg::op_t   op,
  input  rfas_pkg::data_t a,
  input  rfas_pkg::data_t b,
  output rfas_pkg::data_t y
);

  logic                         big_shift;
  logic [rfas_pkg::SHAMT_W-1:0] shamt;

  assign big_shift = (b >= rfas_pkg::SHIFT_LIMIT);
  assign shamt     = b[rfas_pkg::SHAMT_W-1:0];

  always_comb begin
    case (op)
      rfas_pkg::OP_ADD: y = a + b;
      rfas_pkg::OP_SUB: y = a - b;
      rfas_pkg::OP_AND: y = a & b;
      rfas_pkg::OP_OR:  y = a | b;
      rfas_pkg::OP_XOR: y = a ^ b;
      rfas_pkg::OP_SHL: y = big_shift ? '0 : (a << shamt);
      rfas_pkg::OP_SHR: y = big_shift ? '0 : (a >> shamt);
      rfas_pkg::OP_CMP: begin
        if (a > b) begin
          y = rfas_pkg::CMP_GT;
        end else if (a < b) begin
          y = rfas_pkg::CMP_LT;
        end else begin
          y = rfas_pkg::CMP_EQ;
        end
      end
      default: y = '0;
    endcase
  end

endmodule

[design/register_file_alu_step_core.sv]
// ----------------------------------------------------------------------------
// register_file_alu_step_core: two-operand register ALU, one instruction a cycle unless the output stalls
//
// Each input item is a 16-bit instruction: bits 15:13 name the destination,
// which is also the first source, bits 12:10 the second source and bits 4:2
// the operation. Each item yields one result item carrying the ALU result and
// the destination's contents from before the write-back.
// Both channels use valid/ready. An item accepted at one clock edge is read
// from the register file at that edge, goes through the ALU in the next cycle
// and is captured in the output register, raising out_valid, once the operand
// stage advances. One item is accepted every cycle while the output does not
// stall; the register-file read, ALU and write-back follow in that order, and a
// result that the next instruction needs is forwarded straight from the ALU.
// A synchronous reset empties both stages and returns every register to its
// reset contents (15, 7, 12, 1, 9, 2, 22, 7). When the receiver stalls, the
// output register holds its item, the operand stage fills behind it and
// in_ready then falls until out_ready returns.
// ----------------------------------------------------------------------------
module register_file_alu_step_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result,
  output logic [15:0] out_previous_value
);

  logic                in_accept;
  logic                s1_adv;
  rfas_pkg::reg_addr_t in_ra, in_rb;
  rfas_pkg::op_t       in_op;

  logic                s1_vld_r;
  rfas_pkg::op_t       s1_op_r;
  rfas_pkg::reg_addr_t s1_ra_r;
  logic                fwd_a_r, fwd_b_r;
  rfas_pkg::data_t     fwd_val_r;

  rfas_pkg::data_t     rf_a, rf_b;
  rfas_pkg::data_t     op_a, op_b, alu_y;
  rfas_pkg::rf_wr_t    wr;

  logic                out_valid_r;
  rfas_pkg::data_t     out_result_r, out_prev_r;

  assign in_ra = in_instruction[rfas_pkg::RA_LSB +: rfas_pkg::REG_AW];
  assign in_rb = in_instruction[rfas_pkg::RB_LSB +: rfas_pkg::REG_AW];
  assign in_op = rfas_pkg::op_t'(in_instruction[rfas_pkg::OP_LSB +: rfas_pkg::OP_W]);

  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_vld_r || s1_adv;
  assign in_accept = in_valid && in_ready;

  // The operand stage retires into the output register at every edge where it
  // advances, so its write-back lands at the same edge as a new item's read.
  assign wr.en   = s1_vld_r && s1_adv;
  assign wr.addr = s1_ra_r;
  assign wr.data = alu_y;

  rfas_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_accept),
    .rd_addr_a (in_ra),
    .rd_addr_b (in_rb),
    .wr        (wr),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b)
  );

  assign op_a = fwd_a_r ? fwd_val_r : rf_a;
  assign op_b = fwd_b_r ? fwd_val_r : rf_b;

  rfas_alu u_alu (
    .op (s1_op_r),
    .a  (op_a),
    .b  (op_b),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  // On acceptance any item in the operand stage is retiring, so its result
  // replaces the stale register-file read where the addresses match.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r   <= in_op;
      s1_ra_r   <= in_ra;
      fwd_a_r   <= s1_vld_r && (s1_ra_r == in_ra);
      fwd_b_r   <= s1_vld_r && (s1_ra_r == in_rb);
      fwd_val_r <= alu_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      out_result_r <= alu_y;
      out_prev_r   <= op_a;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_previous_value = out_prev_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_vld_r)
    else $error("accepted item did not reach the operand stage");

  a_retire_payload: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> (out_valid && out_result == $past(alu_y)
               && out_previous_value == $past(op_a)))
    else $error("retiring item not captured in the output register");

endmodule
